/* src/vssp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vssp_pkg
// shared types and constants of the variable speed sample player
// ----------------------------------------------------------------------------
package vssp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CMD_W    = 3;
  localparam int LADDR_W  = 14;
  localparam int FRAC_W   = 17;
  localparam int COUNT_W  = 15;
  localparam int EIDX_W   = 15;
  localparam int SPEED_W  = 24;
  localparam int OIDX_W   = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEEK = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd3;

  localparam logic [FRAC_W-1:0] SEEK_FULL = 17'd65536;
  localparam logic [OIDX_W-1:0] OIDX_MAX  = 14'd16383;

  // how the output register finds its sample
  typedef enum logic [1:0] {
    OK_HOLD       = 2'd0,
    OK_ZERO_CLEAR = 2'd1,
    OK_ZERO_KEEP  = 2'd2,
    OK_MEM        = 2'd3
  } out_kind_t;

  typedef struct packed {
    out_kind_t          kind;
    logic               playing;
    logic [OIDX_W-1:0]  index;
  } s1_t;

endpackage
`default_nettype wire

/* src/variable_speed_sample_player_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_speed_sample_player_unit
// plays a stored sample buffer at a signed fractional speed
// ----------------------------------------------------------------------------
// Takes one command per clock and returns one result per command, in the cycle
// after the command is accepted. The result sits in an output register, and
// a new command is taken in any cycle in which that register is empty or its
// result is taken, so commands flow at one per clock while the result side
// keeps up. The rate is set by the sample buffer, which has a single write
// port (load) and a single read port (tick) with registered read data,
// and by the combinational position update (add and end compare, or the seek
// multiply). The buffer needs no clearing pass after reset.
module variable_speed_sample_player_unit #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int FRAC_BITS    = 16
) (
  input  wire         clk,
  input  wire         rst,
  // command stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // load_address[13:0], sample_value[29:14],
                                 // seek_fraction[46:30], zero[47]
  input  wire  [2:0]  s_tuser,   // command[2:0]
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // sample_out[15:0], playing[16],
                                 // position_index[30:17], zero[31]
  // register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [23:0] cfg_data
);

  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int POS_W  = FRAC_BITS + 17;
  localparam int SH_L   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // registers
  logic signed [vssp_pkg::SPEED_W-1:0] speed_q16;
  logic                                loop_enable;
  logic                                pause;
  logic [vssp_pkg::COUNT_W-1:0]        sample_count;

  // state
  logic signed [POS_W-1:0]             read_position;
  logic                                playing_flag;
  logic [vssp_pkg::SAMPLE_W-1:0]       held_output;

  // output stage
  logic                                s1_valid;
  vssp_pkg::s1_t                       s1;
  vssp_pkg::s1_t                       s1_next;

  // input fields
  logic [vssp_pkg::CMD_W-1:0]          in_cmd;
  logic [vssp_pkg::LADDR_W-1:0]        in_addr;
  logic [vssp_pkg::SAMPLE_W-1:0]       in_sample;
  logic [vssp_pkg::FRAC_W-1:0]         in_frac;

  logic in_fire;
  logic out_fire;

  assign in_cmd    = s_tuser;
  assign in_addr   = s_tdata[13:0];
  assign in_sample = s_tdata[29:14];
  assign in_frac   = s_tdata[46:30];

  assign s_tready  = !s1_valid || m_tready;
  assign m_tvalid  = s1_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign cfg_ready = 1'b1;

  // end index and its fixed point form
  logic [20:0]                  count_sat;
  logic [vssp_pkg::EIDX_W-1:0]  end_idx;
  logic signed [POS_W-1:0]      efix;

  assign count_sat = (21'(sample_count) > 21'(SAMPLE_DEPTH)) ? 21'(SAMPLE_DEPTH)
                                                             : 21'(sample_count);
  assign end_idx   = (count_sat == 21'd0) ? '0 : vssp_pkg::EIDX_W'(count_sat - 21'd1);
  assign efix      = $signed({2'b00, end_idx, {FRAC_BITS{1'b0}}});

  // speed in position units, floor rounding when bits are dropped
  logic signed [POS_W-1:0] speed_ext;
  logic signed [POS_W-1:0] speed_pos;

  assign speed_ext = POS_W'(speed_q16);
  assign speed_pos = (speed_ext <<< SH_L) >>> SH_R;

  // tick position update
  logic signed [POS_W:0]   sum;
  logic signed [POS_W:0]   efix_x;
  logic signed [POS_W-1:0] sum_t;
  logic signed [POS_W-1:0] tick_pos;
  logic                    tick_stop;
  logic [15:0]             fl_inc;
  logic [20:0]             rd_ext;

  assign sum    = (POS_W+1)'(read_position) + (POS_W+1)'(speed_pos);
  assign efix_x = (POS_W+1)'(efix);
  assign sum_t  = POS_W'(sum);

  always_comb begin
    tick_pos  = sum_t;
    tick_stop = 1'b0;
    if (sum > efix_x) begin
      if (loop_enable) begin
        tick_pos = '0;
      end else begin
        tick_stop = 1'b1;
      end
    end else if (sum < 0) begin
      if (loop_enable) begin
        tick_pos = efix;
      end else begin
        tick_stop = 1'b1;
      end
    end
  end

  // tick_pos lies in 0..efix here, so 15 integer bits hold it
  assign fl_inc = {1'b0, tick_pos[FRAC_BITS+14:FRAC_BITS]} + 16'd1;
  assign rd_ext = 21'(fl_inc);

  // seek position
  logic [vssp_pkg::FRAC_W-1:0] frac_clamp;
  logic [31:0]                 seek_prod;
  logic [POS_W+7:0]            seek_wide;
  logic signed [POS_W-1:0]     seek_pos;

  assign frac_clamp = (in_frac > vssp_pkg::SEEK_FULL) ? vssp_pkg::SEEK_FULL : in_frac;
  assign seek_prod  = frac_clamp * end_idx;
  assign seek_wide  = ((POS_W+8)'(seek_prod) << SH_L) >> SH_R;
  assign seek_pos   = $signed(seek_wide[POS_W-1:0]);

  // load address check
  logic [20:0] ld_ext;
  logic        ld_ok;

  assign ld_ext = 21'(in_addr);
  assign ld_ok  = ld_ext < 21'(SAMPLE_DEPTH);

  // command decode
  logic signed [POS_W-1:0] pos_next;
  logic                    playing_next;
  vssp_pkg::out_kind_t     out_kind;
  logic                    rd_want;
  logic                    rd_en;
  logic                    wr_en;

  always_comb begin
    pos_next     = read_position;
    playing_next = playing_flag;
    out_kind     = vssp_pkg::OK_HOLD;
    rd_want      = 1'b0;
    unique case (in_cmd)
      vssp_pkg::CMD_TICK: begin
        if (!playing_flag || pause) begin
          out_kind = vssp_pkg::OK_ZERO_CLEAR;
        end else if (tick_stop) begin
          // position keeps the overshoot, held sample kept
          pos_next     = sum_t;
          playing_next = 1'b0;
          out_kind     = vssp_pkg::OK_ZERO_KEEP;
        end else begin
          pos_next = tick_pos;
          if (fl_inc < {1'b0, end_idx}) begin
            out_kind = vssp_pkg::OK_MEM;
            rd_want  = 1'b1;
          end
        end
      end
      vssp_pkg::CMD_LOAD: begin
        pos_next = '0;
      end
      vssp_pkg::CMD_PLAY: begin
        pos_next     = (speed_q16 > 0) ? '0 : efix;
        playing_next = 1'b1;
      end
      vssp_pkg::CMD_STOP: begin
        pos_next     = '0;
        playing_next = 1'b0;
      end
      vssp_pkg::CMD_SEEK: begin
        pos_next = seek_pos;
      end
      default: begin
      end
    endcase
  end

  assign rd_en = in_fire && rd_want;
  assign wr_en = in_fire && (in_cmd == vssp_pkg::CMD_LOAD) && ld_ok;

  // clamped integer position of the new state
  logic [15:0] int_next;

  assign int_next = pos_next[POS_W-2:FRAC_BITS];

  always_comb begin
    s1_next.kind    = out_kind;
    s1_next.playing = playing_next;
    if (pos_next < 0) begin
      s1_next.index = '0;
    end else if (int_next > 16'(vssp_pkg::OIDX_MAX)) begin
      s1_next.index = vssp_pkg::OIDX_MAX;
    end else begin
      s1_next.index = int_next[vssp_pkg::OIDX_W-1:0];
    end
  end

  // sample buffer
  logic [vssp_pkg::SAMPLE_W-1:0] rd_data;

  vssp_store #(
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ld_ext[ADDR_W-1:0]),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_ext[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_q16    <= 24'sd65536;
      loop_enable  <= 1'b0;
      pause        <= 1'b0;
      sample_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vssp_pkg::REG_SPEED: speed_q16    <= $signed(cfg_data);
        vssp_pkg::REG_LOOP:  loop_enable  <= cfg_data[0];
        vssp_pkg::REG_PAUSE: pause        <= cfg_data[0];
        vssp_pkg::REG_COUNT: sample_count <= cfg_data[vssp_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // position and playing state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_position <= '0;
      playing_flag  <= 1'b0;
    end else if (in_fire) begin
      read_position <= pos_next;
      playing_flag  <= playing_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (out_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  // held sample follows results in order as they leave
  always_ff @(posedge clk) begin
    if (rst) begin
      held_output <= '0;
    end else if (out_fire) begin
      case (s1.kind)
        vssp_pkg::OK_ZERO_CLEAR: held_output <= '0;
        vssp_pkg::OK_MEM:        held_output <= rd_data;
        default: begin
        end
      endcase
    end
  end

  logic [vssp_pkg::SAMPLE_W-1:0] sample_out;

  always_comb begin
    unique case (s1.kind)
      vssp_pkg::OK_MEM:  sample_out = rd_data;
      vssp_pkg::OK_HOLD: sample_out = held_output;
      default:           sample_out = '0;
    endcase
  end

  assign m_tdata = {1'b0, s1.index, s1.playing, sample_out};

  // checks
  a_clear_zeroes_held: assert property (@(posedge clk) disable iff (rst)
    (out_fire && s1.kind == vssp_pkg::OK_ZERO_CLEAR) |=> (held_output == '0))
    else $error("held sample not cleared after idle tick");

  a_play_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd == vssp_pkg::CMD_PLAY) |=> (playing_flag && s1.playing))
    else $error("play transaction did not set playing");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd == vssp_pkg::CMD_STOP) |=>
      (!playing_flag && read_position == '0 && s1.index == '0))
    else $error("stop transaction did not clear position");

  a_read_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (in_cmd == vssp_pkg::CMD_TICK && playing_flag && !pause && !wr_en))
    else $error("buffer read outside a playing tick");

endmodule
`default_nettype wire

/* src/vssp_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vssp_store
// sample buffer: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module vssp_store #(
  parameter int DEPTH = 16384
) (
  input  wire                                   clk,
  input  wire                                   wr_en,
  input  wire  [$clog2(DEPTH)-1:0]              wr_addr,
  input  wire  [vssp_pkg::SAMPLE_W-1:0]         wr_data,
  input  wire                                   rd_en,
  input  wire  [$clog2(DEPTH)-1:0]              rd_addr,
  output logic [vssp_pkg::SAMPLE_W-1:0]         rd_data
);

  logic [vssp_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sim/vssp_playback_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssp_playback_checker
// watches the command, result and register channels of the sample player,
// predicts each result from its own copy of the player state and compares
// ----------------------------------------------------------------------------
module vssp_playback_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [47:0] s_tdata,   // load_address[13:0], sample_value[29:14],
                                // seek_fraction[46:30], zero[47]
  input  wire [2:0]  s_tuser,   // command[2:0]
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [31:0] m_tdata,   // sample_out[15:0], playing[16],
                                // position_index[30:17], zero[31]
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [23:0] cfg_data,
  output int         mismatches,
  output int         pending,
  output int         results_checked
);
  import vssp_pkg::*;

  localparam int DEPTH = 16384;
  localparam int FRAC  = 16;

  // packed so that it lines up with m_tdata[30:0]
  typedef struct packed {
    logic [OIDX_W-1:0]          index;
    logic                       playing;
    logic signed [SAMPLE_W-1:0] smp;
  } player_result_t;

  logic signed [SAMPLE_W-1:0] sample_mem [0:DEPTH-1];
  longint                     play_pos;
  bit                         is_playing;
  logic signed [SAMPLE_W-1:0] last_out;
  logic signed [SPEED_W-1:0]  speed;
  bit                         looping;
  bit                         paused;
  logic [COUNT_W-1:0]         n_samples;
  player_result_t             due_q[$];

  function automatic longint last_index();
    longint c;
    c = (n_samples > DEPTH) ? DEPTH : n_samples;
    return (c == 0) ? 0 : c - 1;
  endfunction

  function automatic logic [OIDX_W-1:0] pos_readout();
    longint whole;
    if (play_pos < 0) return '0;
    whole = play_pos >>> FRAC;
    if (whole > longint'(OIDX_MAX)) return OIDX_MAX;
    return whole[OIDX_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] play_tick();
    longint e;
    longint e_fx;
    longint whole;
    e = last_index();
    e_fx = e * (longint'(1) << FRAC);
    if (!is_playing || paused) begin
      last_out = '0;
      return '0;
    end
    play_pos += longint'(speed);
    // running off either end: wrap when looping, else stop and keep the position
    if (play_pos > e_fx) begin
      if (looping) begin
        play_pos = 0;
      end else begin
        is_playing = 1'b0;
        return '0;
      end
    end
    if (play_pos < 0) begin
      if (looping) begin
        play_pos = e_fx;
      end else begin
        is_playing = 1'b0;
        return '0;
      end
    end
    whole = play_pos >>> FRAC;
    if (whole + 1 < e && whole + 1 < DEPTH) last_out = sample_mem[whole + 1];
    return last_out;
  endfunction

  function automatic player_result_t predict_command(logic [CMD_W-1:0] cmd,
      logic [LADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] smp, logic [FRAC_W-1:0] frac);
    player_result_t             r;
    logic [FRAC_W-1:0]          f;
    logic signed [SAMPLE_W-1:0] o;
    o = last_out;
    case (cmd)
      CMD_TICK: o = play_tick();
      CMD_LOAD: begin
        sample_mem[addr] = smp;
        play_pos = 0;
      end
      CMD_PLAY: begin
        play_pos = (speed > 0) ? 0 : last_index() * (longint'(1) << FRAC);
        is_playing = 1'b1;
      end
      CMD_STOP: begin
        play_pos = 0;
        is_playing = 1'b0;
      end
      CMD_SEEK: begin
        f = (frac > SEEK_FULL) ? SEEK_FULL : frac;
        play_pos = longint'(f) * last_index();
      end
      default: ;
    endcase
    if (cmd != CMD_TICK) o = last_out;
    r.smp = o;
    r.playing = is_playing;
    r.index = pos_readout();
    return r;
  endfunction

  always @(posedge clk) begin
    player_result_t got;
    player_result_t want;
    if (rst) begin
      play_pos = 0;
      is_playing = 1'b0;
      last_out = '0;
      speed = 24'sd65536;
      looping = 1'b0;
      paused = 1'b0;
      n_samples = '0;
      due_q.delete();
    end else begin
      // a result always belongs to a command accepted at an earlier edge
      if (m_tvalid && m_tready) begin
        got = m_tdata[30:0];
        results_checked++;
        if (due_q.size() == 0) begin
          mismatches++;
          $error("result with no command pending: sample_out %0d, playing %0d, index %0d",
                 got.smp, got.playing, got.index);
        end else begin
          want = due_q.pop_front();
          if (got.smp !== want.smp) begin
            mismatches++;
            $error("sample_out: expected %0d, got %0d", want.smp, got.smp);
          end
          if (got.playing !== want.playing) begin
            mismatches++;
            $error("playing: expected %0d, got %0d", want.playing, got.playing);
          end
          if (got.index !== want.index) begin
            mismatches++;
            $error("position_index: expected %0d, got %0d", want.index, got.index);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED: speed = cfg_data;
          REG_LOOP:  looping = cfg_data[0];
          REG_PAUSE: paused = cfg_data[0];
          REG_COUNT: n_samples = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        due_q.push_back(predict_command(s_tuser, s_tdata[13:0], s_tdata[29:14],
                                        s_tdata[46:30]));
    end
    pending <= due_q.size();
  end

endmodule

/* sim/variable_speed_sample_player_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_speed_sample_player_unit_test
// drives commands and register settings into the sample player; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module variable_speed_sample_player_unit_test;
  import vssp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;
  localparam logic signed [SPEED_W-1:0] SPEED_ONE = 24'sd65536;

  localparam int PRELOAD       = 128;    // entries written at the bottom of the buffer
  localparam int TOP_WINDOW    = 32;     // entries written at the top of the buffer
  localparam int DEPTH         = 16384;
  localparam int N_PHASES      = 28;
  localparam int HOLD_PHASE    = 6;
  localparam int PHASE_ITEMS   = 28;
  localparam int OVER_TICKS    = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  wire         s_tready;
  logic [47:0] s_tdata;   // load_address[13:0], sample_value[29:14],
                          // seek_fraction[46:30], zero[47]
  logic [2:0]  s_tuser;   // command[2:0]
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [31:0] m_tdata;   // sample_out[15:0], playing[16],
                          // position_index[30:17], zero[31]
  logic        cfg_valid;
  wire         cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  int mismatches;
  int pending;
  int results_checked;

  int sender_pct   = 0;
  int receiver_pct = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int n_cycles     = 0;
  int n_cmds       = 0;
  int n_ticks      = 0;
  int n_loads      = 0;
  int n_settings   = 0;

  variable_speed_sample_player_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vssp_playback_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("variable_speed_sample_player_unit: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      m_tready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_pct);
    end
  end

  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [LADDR_W-1:0] addr,
                               input logic [SAMPLE_W-1:0] smp, input logic [FRAC_W-1:0] frac);
    while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {1'b0, frac, smp, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_cmds++;
    if (cmd == CMD_TICK) n_ticks++;
    if (cmd == CMD_LOAD) n_loads++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic signed [SPEED_W-1:0] spd, input bit lp,
                               input bit ps, input logic [COUNT_W-1:0] cnt);
    wait_drained();
    write_register(REG_SPEED, spd);
    write_register(REG_LOOP, {23'd0, lp});
    write_register(REG_PAUSE, {23'd0, ps});
    write_register(REG_COUNT, {9'd0, cnt});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // counts never reach past the written part of the buffer
  task automatic choose_setting(input int phase, output logic signed [SPEED_W-1:0] spd,
                                output bit lp, output bit ps, output logic [COUNT_W-1:0] cnt);
    int max_cnt;
    max_cnt = PRELOAD;
    lp = $urandom_range(0, 1);
    ps = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 9))
      0: spd = SPEED_MIN;
      1: spd = SPEED_MAX;
      2: spd = '0;
      3: spd = SPEED_ONE;
      4: spd = -SPEED_ONE;
      5, 6: spd = $urandom_range(0, 8 * 65536) - 4 * 65536;
      7: begin
        spd = $urandom_range(1, 65535);
        if ($urandom_range(0, 1)) spd = -spd;
      end
      default: spd = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = 2;
      3: cnt = max_cnt;
      4: cnt = max_cnt - 1;
      default: cnt = $urandom_range(3, max_cnt);
    endcase
    // fixed corners: low-end stop, empty buffer, one sample, speed extremes, pause
    case (phase)
      0: begin spd = -SPEED_ONE; lp = 0; ps = 0; cnt = 16; end
      1: begin spd = '0; lp = 1; ps = 0; cnt = 0; end
      2: begin spd = SPEED_MAX; lp = 1; ps = 0; cnt = 1; end
      3: begin spd = SPEED_MIN; lp = 1; ps = 0; cnt = PRELOAD; end
      4: begin spd = SPEED_ONE; lp = 0; ps = 1; cnt = 100; end
      default: ;
    endcase
  endtask

  task automatic random_command();
    int                 r;
    logic [CMD_W-1:0]   cmd;
    logic [FRAC_W-1:0]  frac;
    r = $urandom_range(0, 99);
    if (r < 55)      cmd = CMD_TICK;
    else if (r < 66) cmd = CMD_PLAY;
    else if (r < 74) cmd = CMD_SEEK;
    else if (r < 82) cmd = CMD_LOAD;
    else if (r < 88) cmd = CMD_STOP;
    else if (r < 93) cmd = $urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST);
    else             cmd = CMD_TICK;
    // mostly in range, sometimes past the end so the clamp gets used
    frac = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
    offer_command(cmd, $urandom_range(0, DEPTH - 1), $urandom(), frac);
  endtask

  initial begin
    logic signed [SPEED_W-1:0] spd;
    bit                        lp;
    bit                        ps;
    logic [COUNT_W-1:0]        cnt;
    logic [SAMPLE_W-1:0]       corner_smp [0:7];
    corner_smp = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                   16'hFFFF, 16'h1234, 16'hC000, 16'h4000};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_SPEED;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: sample extremes, every command, seek clamp, idle tick
    apply_setting(SPEED_ONE, 1'b0, 1'b0, 15'd8);
    for (int a = 0; a < 8; a++) offer_command(CMD_LOAD, a, corner_smp[a], '0);
    offer_command(CMD_LOAD, DEPTH - 1, 16'h5A5A, '1);
    offer_command(CMD_TICK, '1, '1, '1);
    offer_command(CMD_PLAY, '0, '0, '0);
    repeat (3) offer_command(CMD_TICK, '0, '0, '0);
    offer_command(CMD_SEEK, '0, '0, 17'd0);
    offer_command(CMD_SEEK, '0, '0, SEEK_FULL);
    offer_command(CMD_SEEK, '0, '0, 17'd131071);
    offer_command(CMD_SEEK, '0, '0, 17'd32768);
    offer_command(CMD_TICK, '0, '0, '0);
    offer_command(CMD_UNUSED_FIRST, '1, '1, '1);
    offer_command(CMD_UNUSED_LAST, '0, '0, '0);
    offer_command(CMD_STOP, '0, '0, '0);
    offer_command(CMD_TICK, '0, '0, '0);
    offer_command(CMD_PLAY, '0, '0, '0);
    offer_command(CMD_TICK, '0, '0, '0);

    for (int a = 0; a < PRELOAD; a++) offer_command(CMD_LOAD, a, $urandom(), $urandom());
    for (int a = 0; a < TOP_WINDOW; a++)
      offer_command(CMD_LOAD, DEPTH - TOP_WINDOW + a, $urandom(), $urandom());

    // oversized counts: end index saturates, playback stays near the top and
    // wraps to the written bottom of the buffer
    apply_setting(-SPEED_ONE, 1'b0, 1'b0, 15'(DEPTH + 1));
    offer_command(CMD_PLAY, '0, '0, '0);
    repeat (OVER_TICKS) offer_command(CMD_TICK, '0, '0, '0);
    apply_setting(SPEED_ONE, 1'b1, 1'b0, 15'(DEPTH));
    repeat (OVER_TICKS + 4) offer_command(CMD_TICK, '0, '0, '0);
    apply_setting(SPEED_MAX, 1'b0, 1'b0, 15'h7FFF);
    offer_command(CMD_SEEK, '0, '0, 17'd131071);
    offer_command(CMD_TICK, '0, '0, '0);
    offer_command(CMD_TICK, '0, '0, '0);

    for (int p = 0; p < N_PHASES; p++) begin
      choose_setting(p, spd, lp, ps, cnt);
      apply_setting(spd, lp, ps, cnt);
      case (p % 4)
        0: begin sender_pct <= 0; receiver_pct <= 0; end
        1: begin sender_pct <= 48; receiver_pct <= 0; end
        2: begin sender_pct <= 0; receiver_pct <= 48; end
        default: begin sender_pct <= 35; receiver_pct <= 35; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == HOLD_PHASE && i == 4) hold_asked <= hold_asked + 1;
        random_command();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d commands (%0d ticks, %0d loads) under %0d register settings",
             n_cmds, n_ticks, n_loads, n_settings);
    $display("compared %0d results, with oversized counts and a %0d-cycle output hold-off",
             results_checked, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("variable_speed_sample_player_unit: match");
    end else begin
      $display("variable_speed_sample_player_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/vssp_pkg.sv
src/vssp_store.sv
src/variable_speed_sample_player_unit.sv
sim/vssp_playback_checker.sv
sim/variable_speed_sample_player_unit_test.sv
